// ===== design/bitmap_range_set_find_first_top_assert.svh =====
// ----------------------------------------------------------------------------
// Bitmap range set / find-first assertion macros
// Clocked assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RANGE_SET_FIND_FIRST_TOP_ASSERT_SVH
`define BITMAP_RANGE_SET_FIND_FIRST_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Implication checked on every clock edge outside reset
`define BRSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition in one cycle implies a property in the next cycle
`define BRSF_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) cond |=> prop) else $error(msg);
`else
`define BRSF_ASSERT(lbl, prop, msg)
`define BRSF_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

// ===== design/brsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap range set / find-first package
// Default sizes, request codes and controller states.
// ----------------------------------------------------------------------------
package brsf_pkg;

  // Default bitmap geometry
  localparam int MAP_BITS_DEF  = 4096;
  localparam int WORD_BITS_DEF = 32;

  // Width of every bit index field on the ports
  localparam int IDX_W = 13;

  // Request codes
  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_FIND = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage

// ===== design/bitmap_range_set_find_first_top.sv =====
// ----------------------------------------------------------------------------
// Bitmap range set / find-first
// Word-memory bitmap with run write and lowest-set-bit scan.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_ready) carries one request word. req_type
// REQ_SET writes fill_value into bits [range_start, range_start+bit_count),
// REQ_FIND returns the lowest set bit in [range_start, range_end). Ranges are
// clipped to MAP_BITS. Every request gives exactly one output word on
// out_valid / out_ready: found_index and bit_found (both zero for a set).
// One request is processed at a time. A request passes through setup
// (accept, word-index multiply, issue), then a walk over the memory words it
// touches, then a load of the output register. The walk through the word
// memory, read-modify-write for a set, moves one word per cycle and sets the
// rate. An empty range skips the setup and the walk. A find stops at the
// word holding the first set bit.
// After reset the memory is cleared one word per cycle, all NUM_WORDS words
// (128 by default), with in_ready low. A finished result waits in the
// output register while the receiver stalls; the next request may be
// accepted then, but its own result is held back until the output frees.
// ----------------------------------------------------------------------------
`include "bitmap_range_set_find_first_top_assert.svh"

module bitmap_range_set_find_first_top #(
  parameter int MAP_BITS  = brsf_pkg::MAP_BITS_DEF,
  parameter int WORD_BITS = brsf_pkg::WORD_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       req_type,
  input  logic [brsf_pkg::IDX_W-1:0] range_start,
  input  logic [brsf_pkg::IDX_W-1:0] bit_count,
  input  logic                       fill_value,
  input  logic [brsf_pkg::IDX_W-1:0] range_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [brsf_pkg::IDX_W-1:0] found_index,
  output logic                       bit_found
);
  import brsf_pkg::*;

  localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CW = ($clog2(MAP_BITS + 1) > IDX_W + 1) ? $clog2(MAP_BITS + 1) : IDX_W + 1;
  localparam int OW = $clog2(WORD_BITS + 1);
  localparam int LW = $clog2(WORD_BITS);
  // Reciprocal for start / WORD_BITS, exact for every IDX_W-bit start
  localparam int SH    = IDX_W + LW;
  localparam int RW    = IDX_W + 1;
  localparam int PW    = IDX_W + RW;
  localparam int RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;

  localparam logic [CW-1:0] MAP_C   = CW'(MAP_BITS);
  localparam logic [CW-1:0] WORD_C  = CW'(WORD_BITS);
  localparam logic [AW-1:0] LAST_WA = AW'(NUM_WORDS - 1);

  // Word memory
  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;

  state_t state, state_next;

  // Request registers
  logic          req_find;
  logic          fill;
  logic [CW-1:0] start_r;
  logic [CW-1:0] lim_r;
  logic [PW-1:0] prod;

  // Walk registers: issue stage and evaluate stage
  logic [AW-1:0] issue_word;
  logic [CW-1:0] issue_base;
  logic          ev_valid;
  logic [AW-1:0] ev_word;
  logic [CW-1:0] ev_base;
  logic [AW-1:0] clr_addr;

  // Result held until the output register frees
  logic [IDX_W-1:0] res_idx;
  logic             res_found;

  // Combinational helpers
  logic                 accept;
  logic [CW-1:0]        run_sum;
  logic [CW-1:0]        run_stop;
  logic [CW-1:0]        end_clip;
  logic [CW-1:0]        lim_in;
  logic                 empty_in;
  logic [PW-SH-1:0]     quot;
  logic [CW-1:0]        rem;
  logic                 last_word;
  logic [OW-1:0]        lo;
  logic [OW-1:0]        hi;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] masked;
  logic                 hit;
  logic [LW-1:0]        off;
  logic                 finish;
  logic                 out_free;

  // Clip the incoming range
  always_comb begin
    run_sum  = CW'(range_start) + CW'(bit_count);
    run_stop = (run_sum > MAP_C) ? MAP_C : run_sum;
    end_clip = (CW'(range_end) > MAP_C) ? MAP_C : CW'(range_end);
    lim_in   = (req_type == REQ_FIND) ? end_clip : run_stop;
    empty_in = CW'(range_start) >= lim_in;
    quot     = prod[PW-1:SH];
  end

  // Bit window of the word under evaluation, and its lowest set bit
  always_comb begin
    rem       = lim_r - ev_base;
    last_word = rem <= WORD_C;
    hi        = last_word ? OW'(rem) : OW'(WORD_BITS);
    lo        = (start_r > ev_base) ? OW'(start_r - ev_base) : '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (OW'(b) >= lo) && (OW'(b) < hi);
    end
    masked = rdata & mask;
    hit    = |masked;
    off    = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (masked[b]) begin
        off = LW'(b);
      end
    end
  end

  // Next state, memory control and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    waddr      = ev_word;
    wdata      = (rdata & ~mask) | (fill ? mask : '0);
    finish     = 1'b0;
    out_free   = !out_valid || out_ready;
    accept     = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_addr;
        wdata  = '0;
        if (clr_addr == LAST_WA) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        accept   = in_valid;
        if (in_valid) begin
          state_next = empty_in ? ST_DONE : ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        mem_re = issue_base < lim_r;
        finish = ev_valid && (last_word || (req_find && hit));
        mem_we = ev_valid && !req_find;
        if (finish) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mem[issue_word];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      ev_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      ev_valid <= mem_re && !finish;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request, walk and result registers
  always_ff @(posedge clk) begin
    // Latch the request and start the word-index multiply
    if (accept) begin
      req_find  <= req_type;
      fill      <= fill_value;
      start_r   <= CW'(range_start);
      lim_r     <= lim_in;
      prod      <= PW'(range_start) * PW'(RECIP);
      res_found <= 1'b0;
      res_idx   <= (req_type == REQ_FIND) ? range_start : '0;
    end
    // Load the first word and its base index
    if (state == ST_SETUP) begin
      issue_word <= AW'(quot);
      issue_base <= CW'(quot) * WORD_C;
    end
    // Advance the issue stage and hand the word to the evaluate stage
    if (mem_re) begin
      issue_word <= issue_word + AW'(1);
      issue_base <= issue_base + WORD_C;
      ev_word    <= issue_word;
      ev_base    <= issue_base;
    end
    // Capture the result of the walk
    if (finish) begin
      if (!req_find) begin
        res_idx   <= '0;
        res_found <= 1'b0;
      end else if (hit) begin
        res_idx   <= IDX_W'(ev_base + CW'(off));
        res_found <= 1'b1;
      end else begin
        res_idx   <= IDX_W'(lim_r);
        res_found <= 1'b0;
      end
    end
    // Drive the output word
    if (state == ST_DONE && out_free) begin
      found_index <= res_idx;
      bit_found   <= res_found;
    end
  end

  `BRSF_ASSERT(a_no_rw_clash, (mem_we && mem_re) |-> (waddr != issue_word),
               "read and write hit the same word")
  `BRSF_ASSERT(a_eval_in_range, ev_valid |-> (ev_base < lim_r),
               "evaluated word lies beyond the range")
  `BRSF_ASSERT(a_hit_in_range, (state == ST_DONE && res_found) |->
               ((CW'(res_idx) >= start_r) && (CW'(res_idx) < lim_r)),
               "found bit outside the scan range")
  `BRSF_ASSERT_NEXT(a_done_drives_out, (state == ST_DONE && out_free),
                    (out_valid && state == ST_IDLE), "result not presented")

endmodule
